// ===== rtl/core/ddd_pkg.sv =====
// Shared types, constants and bit-step functions for the differential descrambler decoder.
package ddd_pkg;

   localparam int unsigned HIST_WIDTH = 17;
   localparam int unsigned RUN_WIDTH = 7;
   localparam int unsigned TAP_NEAR = 13;
   localparam int unsigned TAP_FAR = 16;
   localparam logic [RUN_WIDTH-1:0] RUN_LIMIT = 7'd64;
   localparam int unsigned BITS_PER_SYMBOL = 4;

   typedef struct packed {
      logic [1:0] dibit;
      logic [1:0] position;
   } ddd_symbol_bits_type;

   typedef struct packed {
      logic [HIST_WIDTH-1:0] history;
      logic [RUN_WIDTH-1:0]  run_count;
   } ddd_scr_state_type;

   typedef struct packed {
      ddd_scr_state_type state;
      logic              out_bit;
   } ddd_scr_step_type;

   // quadrant change (mod 4) to dibit
   function automatic logic [1:0] ddd_dibit_map(input logic [1:0] delta);
      logic [1:0] dibit;
      unique case (delta)
         2'd0: dibit = 2'd1;
         2'd1: dibit = 2'd0;
         2'd2: dibit = 2'd2;
         2'd3: dibit = 2'd3;
         default: dibit = 2'd1;
      endcase
      return dibit;
   endfunction

   // one bit through the self-synchronizing descrambler
   function automatic ddd_scr_step_type ddd_scr_step(input ddd_scr_state_type cur,
                                                     input logic in_bit);
      ddd_scr_step_type res;
      logic [RUN_WIDTH-1:0] count;
      res.out_bit = in_bit ^ cur.history[TAP_NEAR] ^ cur.history[TAP_FAR];
      res.state.history = {cur.history[HIST_WIDTH-2:0], in_bit};
      count = cur.run_count;
      if (count >= RUN_LIMIT) begin
         res.out_bit = ~res.out_bit;
         count = '0;
      end
      res.state.run_count = in_bit ? count + 1'b1 : '0;
      return res;
   endfunction

endpackage

// ===== rtl/core/ddd_diff_decode.sv =====
// Differential quadrant decoder: keeps the previous quadrant and maps the change to a dibit.
module ddd_diff_decode
   import ddd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [3:0]          symbol_index,
   output ddd_symbol_bits_type symbol_bits
);

   logic [1:0] prev_quadrant_ff;
   logic [1:0] prev_quadrant_in;
   logic [1:0] quadrant;

   assign quadrant = symbol_index[3:2];
   assign symbol_bits.dibit = ddd_dibit_map(quadrant - prev_quadrant_ff);
   assign symbol_bits.position = symbol_index[1:0];
   assign prev_quadrant_in = step_en ? quadrant : prev_quadrant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_quadrant_ff <= '0;
      end else begin
         prev_quadrant_ff <= prev_quadrant_in;
      end
   end

endmodule

// ===== rtl/core/ddd_descrambler.sv =====
// Descrambler with taps 14 and 17 and ones-run inversion, unrolled over up to four bits.
module ddd_descrambler
   import ddd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                sixteen_point_mode,
   input  ddd_symbol_bits_type symbol_bits,
   output logic [3:0]          data_bits
);

   ddd_scr_state_type state_ff;
   ddd_scr_state_type state_in;
   ddd_scr_state_type chain [BITS_PER_SYMBOL+1];
   ddd_scr_step_type  step_res [BITS_PER_SYMBOL];
   logic [BITS_PER_SYMBOL-1:0] in_bits;
   logic [BITS_PER_SYMBOL-1:0] scr_bits;

   assign in_bits = {symbol_bits.dibit, symbol_bits.position};

   always_comb begin
      chain[0] = state_ff;
      for (int i = 0; i < BITS_PER_SYMBOL; i++) begin
         step_res[i] = ddd_scr_step(chain[i], in_bits[BITS_PER_SYMBOL-1-i]);
         scr_bits[BITS_PER_SYMBOL-1-i] = step_res[i].out_bit;
         if (i < 2 || sixteen_point_mode) begin
            chain[i+1] = step_res[i].state;
         end else begin
            chain[i+1] = chain[i];
         end
      end
   end

   assign data_bits = sixteen_point_mode ? scr_bits : {2'b00, scr_bits[3:2]};
   assign state_in = step_en ? chain[BITS_PER_SYMBOL] : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/differential_descrambler_decoder.sv =====
// Top level of the differential descrambler decoder.
// One symbol index enters per item; the block returns one item per symbol with the descrambled
// bits and the raw differential dibit. An item passes through the input register and then the
// result register, with the decode and the four-bit unrolled descrambler between them. A new
// item is taken every cycle while the result side keeps up. The mode register is sampled when
// an item leaves the input register.
module differential_descrambler_decoder
   import ddd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // sixteen_point_mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [3:0] symbol_index, [7:4] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata      // [3:0] data_bits, [5:4] raw_dibit, [7:6] zero
);

   logic                mode_ff;
   logic                mode_in;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [3:0]          in_sym_ff;
   logic [3:0]          in_sym_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [3:0]          rsp_data_ff;
   logic [3:0]          rsp_data_in;
   logic [1:0]          rsp_dibit_ff;
   logic [1:0]          rsp_dibit_in;
   logic                advance;
   logic                req_take;
   ddd_symbol_bits_type symbol_bits;
   logic [3:0]          data_bits;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign in_sym_in = req_take ? req_tdata[3:0] : in_sym_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in = advance ? data_bits : rsp_data_ff;
   assign rsp_dibit_in = advance ? symbol_bits.dibit : rsp_dibit_ff;

   ddd_diff_decode u_diff (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .symbol_index (in_sym_ff),
      .symbol_bits  (symbol_bits)
   );

   ddd_descrambler u_scr (
      .clock              (clock),
      .reset              (reset),
      .step_en            (advance),
      .sixteen_point_mode (mode_ff),
      .symbol_bits        (symbol_bits),
      .data_bits          (data_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sym_ff <= in_sym_in;
      rsp_data_ff <= rsp_data_in;
      rsp_dibit_ff <= rsp_dibit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_dibit_ff, rsp_data_ff};

endmodule

// ===== rtl/core/ddd_checker.sv =====
// Port-level checks for the differential descrambler decoder, bound to the top level.
module ddd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00)
      else $error("result padding bits not zero");

   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |-> ##2 rsp_tvalid)
      else $error("item did not reach result within two cycles");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result item without matching input item");

endmodule

bind differential_descrambler_decoder ddd_checker u_ddd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/ddd_decode_monitor.sv =====
// Predicts and checks the differential descrambler decoder result stream.
module ddd_decode_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   output int         outstanding,
   output int         fail_count
);

   localparam logic [6:0] ONES_RUN_LIMIT = 7'd64;
   localparam logic [1:0] DIBIT_OF_DELTA [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

   // packed to match rsp_tdata[5:0]: data_bits low, raw_dibit above
   typedef struct packed {
      logic [1:0] raw_dibit;
      logic [3:0] data_bits;
   } decoded_type;

   decoded_type pending_decodes[$];
   decoded_type want;
   decoded_type got;
   int         errors;
   logic       four_bit_mode;
   logic [1:0] last_quad;
   logic [16:0] scr_hist;
   logic [6:0] ones_run;

   // one bit through the self-synchronizing descrambler, with the ones-run inversion
   function automatic logic descramble(input logic b);
      logic o;
      o = b ^ scr_hist[13] ^ scr_hist[16];
      scr_hist = {scr_hist[15:0], b};
      if (ones_run >= ONES_RUN_LIMIT) begin
         o = ~o;
         ones_run = '0;
      end
      ones_run = b ? ones_run + 7'd1 : 7'd0;
      return o;
   endfunction

   function automatic decoded_type predict_decode(input logic [3:0] sym);
      decoded_type d;
      logic [1:0] delta;
      logic       b3, b2, b1, b0;
      delta = sym[3:2] - last_quad;
      last_quad = sym[3:2];
      d.raw_dibit = DIBIT_OF_DELTA[delta];
      b3 = descramble(d.raw_dibit[1]);
      b2 = descramble(d.raw_dibit[0]);
      if (four_bit_mode) begin
         b1 = descramble(sym[1]);
         b0 = descramble(sym[0]);
         d.data_bits = {b3, b2, b1, b0};
      end else begin
         d.data_bits = {2'b00, b3, b2};
      end
      return d;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending_decodes.delete();
         four_bit_mode = 1'b0;
         last_quad = '0;
         scr_hist = '0;
         ones_run = '0;
         errors = 0;
         outstanding <= 0;
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            pending_decodes.push_back(predict_decode(req_tdata[3:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[5:0];
            if (pending_decodes.size() == 0) begin
               $error("unexpected result item: data_bits %h raw_dibit %h",
                      got.data_bits, got.raw_dibit);
               errors++;
            end else begin
               want = pending_decodes.pop_front();
               if (got.data_bits !== want.data_bits) begin
                  $error("data_bits: expected %h, actual %h", want.data_bits, got.data_bits);
                  errors++;
               end
               if (got.raw_dibit !== want.raw_dibit) begin
                  $error("raw_dibit: expected %h, actual %h", want.raw_dibit, got.raw_dibit);
                  errors++;
               end
               if (rsp_tdata[7:6] !== 2'b00) begin
                  $error("rsp_tdata pad: expected 0, actual %h", rsp_tdata[7:6]);
                  errors++;
               end
            end
         end
         if (csr_wr_en)
            four_bit_mode = csr_wr_data;
         outstanding <= pending_decodes.size();
         fail_count <= errors;
      end
   end

endmodule

// ===== tb/tb.sv =====
// Stimulus, idling and verdict for the differential descrambler decoder.
module tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 250;
   localparam int PHASE_ITEMS  = 125;
   localparam int DRAIN_CYCLES = 4;
   localparam logic [3:0] CORNER_SYMS [8] = '{4'd0, 4'd15, 4'd5, 4'd10,
                                              4'd12, 4'd3, 4'd7, 4'd9};

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   int         outstanding;
   int         fail_count;
   int         idle_cycles;
   logic [1:0] sent_quad;
   int         steady_left;

   differential_descrambler_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ddd_decode_monitor u_monitor (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .outstanding(outstanding),
      .fail_count (fail_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 25);
   endfunction

   task automatic send_symbol(input logic [3:0] sym);
      int g;
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, sym};
      do @(posedge clock); while (!req_tready);
      sent_quad = sym[3:2];
      if (steady_left > 0) begin
         steady_left--;
      end else begin
         if ($urandom_range(0, 19) == 0)
            steady_left = 40;
         g = pick_gap();
         if (g > 0) begin
            req_tvalid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random symbols mixed with runs that feed the descrambler nothing but ones
   task automatic random_phase(input logic m);
      int         count;
      int         run;
      logic [3:0] sym;
      count = 0;
      while (count < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 15) begin
            run = m ? $urandom_range(14, 24) : $urandom_range(30, 50);
            repeat (run) begin
               sym[3:2] = sent_quad + 2'd3;
               sym[1:0] = m ? 2'b11 : 2'($urandom_range(0, 3));
               send_symbol(sym);
               count++;
            end
         end else begin
            send_symbol(4'($urandom_range(0, 15)));
            count++;
         end
      end
   endtask

   initial begin : result_sink
      int seen;
      int stall;
      int quiet;
      bit held;
      seen = 0;
      stall = 0;
      quiet = 0;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset)
            seen++;
         if (seen == HOLD_AT && !held) begin
            held = 1;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && quiet == 0) begin
            if ($urandom_range(0, 19) == 0)
               quiet = 40;
            else
               stall = pick_gap();
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            if (quiet > 0)
               quiet--;
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("differential_descrambler_decoder test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      sent_quad = '0;
      steady_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two-bit mode: extremes and every quadrant step
      write_mode(1'b0);
      foreach (CORNER_SYMS[i])
         send_symbol(CORNER_SYMS[i]);
      drain();

      // four-bit mode: every symbol value, history carried over from two-bit mode
      write_mode(1'b1);
      for (int i = 0; i < 16; i++)
         send_symbol(4'((i * 7) % 16));

      for (int p = 0; p < 4; p++) begin
         drain();
         write_mode(p[0] ? 1'b0 : 1'b1);
         random_phase(p[0] ? 1'b0 : 1'b1);
      end
      drain();

      if (fail_count == 0)
         $display("differential_descrambler_decoder test passed");
      else
         $display("differential_descrambler_decoder test failed");
      $finish;
   end

endmodule
